[src/wbf_pkg.sv]
// ----------------------------------------------------------------------------
// Wavetable buffer fill package
// Shared constants, command codes, waveform selectors and the quarter-wave
// sine table builder used by the wavetable buffer fill core.
// ----------------------------------------------------------------------------
`default_nettype none

package wbf_pkg;

   // Default sizing of the sample table.
   localparam int DEF_MAX_ENTRIES = 1024;
   localparam int DEF_SAMPLE_BITS = 16;

   // Width of the table length register.
   localparam int CFG_W = 11;
   localparam logic [CFG_W-1:0] TABLE_LENGTH_RESET = 11'd1024;

   // Register map.
   localparam int                CSR_ADDR_W            = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_TABLE_LENGTH_ADDR = 3'd0;

   // Command codes.
   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;
   localparam logic [1:0] MODE_FILL  = 2'd3;

   // Waveform selectors.
   localparam logic [3:0] WV_SINE       = 4'd0;
   localparam logic [3:0] WV_COS        = 4'd2;
   localparam logic [3:0] WV_COS_MOD    = 4'd3;
   localparam logic [3:0] WV_SQUARE     = 4'd4;
   localparam logic [3:0] WV_SQUARE_MOD = 4'd5;
   localparam logic [3:0] WV_TRI        = 4'd6;
   localparam logic [3:0] WV_TRI_MOD    = 4'd7;
   localparam logic [3:0] WV_RAMP       = 4'd8;
   localparam logic [3:0] WV_SAW        = 4'd10;
   localparam logic [3:0] WV_SAW_MOD    = 4'd11;

   // pi in Q30.
   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   typedef logic [31:0] qrom_type [256];

   // Quarter-wave sine table: seven-term Taylor sum in Q30, rounded half-up
   // to a sample of sb bits and limited to the largest positive code.
   function automatic qrom_type build_quarter_rom(input int sb);
      qrom_type    rom;
      logic [63:0] x;
      logic [63:0] t;
      logic [63:0] sum;
      logic [63:0] maxv;
      int          sh;
      maxv = (64'd1 << (sb - 1)) - 64'd1;
      sh   = 30 - (sb - 1);
      for (int k = 0; k < 256; k++) begin
         x   = (64'(k) * PI_Q30) >> 9;
         t   = x;
         sum = x;
         for (int n = 1; n <= 6; n++) begin
            t = (((t * x) >> 30) * x) >> 30;
            case (n)
               1:       t = t / 64'd6;
               2:       t = t / 64'd20;
               3:       t = t / 64'd42;
               4:       t = t / 64'd72;
               5:       t = t / 64'd110;
               default: t = t / 64'd156;
            endcase
            if ((n % 2) == 1) begin
               sum = sum - t;
            end else begin
               sum = sum + t;
            end
         end
         if (sh > 0) begin
            sum = (sum + (64'd1 << (sh - 1))) >> sh;
         end else if (sh < 0) begin
            sum = sum << 1;
         end
         if (sum > maxv) begin
            sum = maxv;
         end
         rom[k] = sum[31:0];
      end
      return rom;
   endfunction

endpackage

`default_nettype wire

[src/wbf_divider.sv]
// ----------------------------------------------------------------------------
// Wavetable buffer fill divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wbf_divider #(
   parameter int NUM_W = 26,
   parameter int DEN_W = 11
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  done,
   output logic [NUM_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = denom;
         quo_in  = numer;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_div_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");

   a_div_rem_below: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && den_ff != '0) |-> rem_ff < den_ff)
      else $error("divider remainder not below divisor");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider started while busy");

endmodule

`default_nettype wire

[src/wavetable_buffer_fill_core.sv]
// ----------------------------------------------------------------------------
// Wavetable buffer fill core
// Sample table with read, write, clear and waveform fill commands.
// ----------------------------------------------------------------------------
// Usage: each beat on the req_ channel is one command (read, write, clear or
// fill); each command returns exactly one beat on the rsp_ channel carrying
// the read sample (zero for other commands) and a done flag.
// A write passes through S_FINISH and a read through S_READ and S_FINISH
// before the core takes the next command; the response register loads as
// S_FINISH is left, the single registered table read port setting the
// extra S_READ state of a read.
// A clear sweeps every entry through the write port, one per cycle. A fill
// walks the first L entries (table_length clamped to 1..MAX_ENTRIES); square
// entries are written from S_FILL, mirrored triangle entries via S_MEMRD, and
// every entry that needs a quotient (sine, cosine, ramp, sawtooth and the
// rising triangle quarter) waits in S_DIV on the shared bit-serial divider of
// NUM_W bits, NUM_W being the index width plus the larger of SAMPLE_BITS and 10.
// req_stall is high while a command is in progress. A finished response sits
// in the output register while the receiver stalls; a new command may be
// accepted then, but its response waits until the register frees.
// Reset clears the sequencer and sets table_length to 1024; table contents are
// undefined until written, so no clearing pass runs after reset. The user must
// write the table length register over the APB port while idle; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module wavetable_buffer_fill_core #(
   parameter int MAX_ENTRIES = wbf_pkg::DEF_MAX_ENTRIES,
   parameter int SAMPLE_BITS = wbf_pkg::DEF_SAMPLE_BITS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [1:0]                       req_mode,
   input  wire logic [9:0]                       req_index,
   input  wire logic signed [15:0]               req_sample_in,
   input  wire logic [3:0]                       req_waveform,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic signed [15:0]                    rsp_read_value,
   output logic                                  rsp_done_res,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [wbf_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [31:0]                      pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);

   import wbf_pkg::*;

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int LEN_W = $clog2(MAX_ENTRIES + 1);
   localparam int CW    = (LEN_W > CFG_W) ? LEN_W : CFG_W;
   localparam int FB    = SAMPLE_BITS - 1;
   localparam int NUM_W = IDX_W + ((SAMPLE_BITS > 10) ? SAMPLE_BITS : 10);
   localparam int V_W   = SAMPLE_BITS + 2;
   localparam int XW    = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;

   localparam logic signed [V_W-1:0] ONE_V  = V_W'(1) << FB;
   localparam logic signed [V_W-1:0] MAX_V  = ONE_V - V_W'(1);
   localparam logic signed [V_W-1:0] MIN_V  = -ONE_V;
   localparam logic signed [V_W-1:0] HALF_V = ONE_V >>> 1;
   localparam logic signed [XW-1:0]  MAX_X  = XW'((64'd1 << FB) - 64'd1);
   localparam logic signed [XW-1:0]  MIN_X  = -MAX_X - XW'(1);

   localparam qrom_type QROM = build_quarter_rom(SAMPLE_BITS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CLEAR,
      S_FILL,
      S_DIV,
      S_MEMRD,
      S_FINISH
   } state_type;

   // Configuration register.
   logic [CFG_W-1:0] table_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff <= TABLE_LENGTH_RESET;
      end else if (psel && penable && pwrite && paddr == CSR_TABLE_LENGTH_ADDR) begin
         table_length_ff <= pwdata[CFG_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == CSR_TABLE_LENGTH_ADDR) ? 32'(table_length_ff) : 32'd0;

   // Effective length L, table_length clamped to 1..MAX_ENTRIES.
   logic [CW-1:0]    cfg_wide;
   logic [LEN_W-1:0] eff_len;

   assign cfg_wide = CW'(table_length_ff);

   always_comb begin
      priority if (cfg_wide == '0) begin
         eff_len = LEN_W'(1);
      end else if (cfg_wide > CW'(MAX_ENTRIES)) begin
         eff_len = LEN_W'(MAX_ENTRIES);
      end else begin
         eff_len = LEN_W'(cfg_wide);
      end
   end

   // Read and write address, clipped to L-1.
   logic [CW-1:0]    idx_wide;
   logic [CW-1:0]    last_wide;
   logic [IDX_W-1:0] req_addr;

   assign idx_wide  = CW'(req_index);
   assign last_wide = CW'(eff_len - LEN_W'(1));
   assign req_addr  = (idx_wide > last_wide) ? last_wide[IDX_W-1:0] : idx_wide[IDX_W-1:0];

   // Write data of a write command, limited to the sample range.
   logic signed [XW-1:0]     samp_x;
   logic [SAMPLE_BITS-1:0]   samp_w;

   assign samp_x = XW'(req_sample_in);

   always_comb begin
      priority if (samp_x > MAX_X) begin
         samp_w = MAX_X[SAMPLE_BITS-1:0];
      end else if (samp_x < MIN_X) begin
         samp_w = MIN_X[SAMPLE_BITS-1:0];
      end else begin
         samp_w = samp_x[SAMPLE_BITS-1:0];
      end
   end

   // Sample memory: one write port, one registered read port.
   logic [SAMPLE_BITS-1:0] sample_mem [MAX_ENTRIES];
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   logic [SAMPLE_BITS-1:0] mem_wdata;
   logic                   mem_re;
   logic [IDX_W-1:0]       mem_raddr;
   logic [SAMPLE_BITS-1:0] mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         mem_rdata_ff <= sample_mem[mem_raddr];
      end
   end

   logic signed [V_W-1:0] rd_v;
   logic signed [XW-1:0]  rd_x;

   assign rd_v = V_W'($signed(mem_rdata_ff));
   assign rd_x = XW'($signed(mem_rdata_ff));

   // Shared divider.
   logic             div_start;
   logic [NUM_W-1:0] div_numer;
   logic [LEN_W-1:0] div_denom;
   logic             div_done;
   logic [NUM_W-1:0] div_quot;

   wbf_divider #(
      .NUM_W(NUM_W),
      .DEN_W(LEN_W)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .numer   (div_numer),
      .denom   (div_denom),
      .done    (div_done),
      .quotient(div_quot)
   );

   // Sequencer registers.
   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  fill_counter_ff, fill_counter_in;
   logic [3:0]        wave_ff, wave_in;
   logic [15:0]       res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_value_ff, rsp_value_in;

   // Waveform decode.
   logic is_trig, is_cos, is_square, is_tri, is_ramp, is_saw, is_mod;

   assign is_trig   = wave_ff < WV_SQUARE;
   assign is_cos    = (wave_ff == WV_COS) || (wave_ff == WV_COS_MOD);
   assign is_square = (wave_ff == WV_SQUARE) || (wave_ff == WV_SQUARE_MOD);
   assign is_tri    = (wave_ff == WV_TRI) || (wave_ff == WV_TRI_MOD);
   assign is_ramp   = (wave_ff >= WV_RAMP) && (wave_ff <= WV_SAW_MOD);
   assign is_saw    = (wave_ff == WV_SAW) || (wave_ff == WV_SAW_MOD);
   assign is_mod    = wave_ff[0];

   // Per-entry geometry of the fill.
   logic [LEN_W-1:0] half_len, quarter_len, two_q_m1, mirror_addr, ramp_src;
   logic             below_half, below_quarter;

   assign half_len      = eff_len >> 1;
   assign quarter_len   = eff_len >> 2;
   assign two_q_m1      = (quarter_len << 1) - LEN_W'(1);
   assign mirror_addr   = (fill_counter_ff <= two_q_m1) ? (two_q_m1 - fill_counter_ff) : '0;
   assign ramp_src      = is_saw ? (eff_len - LEN_W'(1) - fill_counter_ff) : fill_counter_ff;
   assign below_half    = fill_counter_ff < half_len;
   assign below_quarter = fill_counter_ff < quarter_len;

   // Sine and cosine from the quotient, through the quarter-wave table.
   logic [9:0]            angle;
   logic [7:0]            rom_idx;
   logic signed [V_W-1:0] trig_mag, trig_v;

   assign angle   = div_quot[9:0] + (is_cos ? 10'd256 : 10'd0);
   assign rom_idx = angle[8] ? (8'd0 - angle[7:0]) : angle[7:0];

   always_comb begin
      if (angle[8] && angle[7:0] == 8'd0) begin
         trig_mag = MAX_V;
      end else begin
         trig_mag = $signed({2'b00, QROM[rom_idx][SAMPLE_BITS-1:0]});
      end
      trig_v = angle[9] ? -trig_mag : trig_mag;
      if (is_mod) begin
         trig_v = (ONE_V + trig_v) >>> 1;
      end
   end

   // Value of the current fill entry, before the range limit.
   logic signed [V_W-1:0] quot_v, fill_v, fill_sat;

   assign quot_v = $signed({1'b0, div_quot[SAMPLE_BITS:0]});

   always_comb begin
      fill_v = '0;
      unique case (state_ff)
         S_DIV: begin
            priority if (is_trig) begin
               fill_v = trig_v;
            end else if (is_tri) begin
               fill_v = is_mod ? (quot_v + HALF_V) : quot_v;
            end else begin
               fill_v = is_mod ? quot_v : (quot_v - ONE_V);
            end
         end
         S_MEMRD: begin
            priority if (below_half) begin
               fill_v = rd_v;
            end else if (is_mod) begin
               fill_v = ONE_V - rd_v;
            end else begin
               fill_v = -rd_v;
            end
         end
         S_IDLE, S_READ, S_CLEAR, S_FILL, S_FINISH: begin
            if (is_square) begin
               fill_v = below_half ? MAX_V : (is_mod ? '0 : MIN_V);
            end
         end
         default: fill_v = '0;
      endcase
      priority if (fill_v > MAX_V) begin
         fill_sat = MAX_V;
      end else if (fill_v < MIN_V) begin
         fill_sat = MIN_V;
      end else begin
         fill_sat = fill_v;
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in        = state_ff;
      fill_counter_in = fill_counter_ff;
      wave_in         = wave_ff;
      res_in          = res_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_value_in    = rsp_value_ff;
      mem_we          = 1'b0;
      mem_waddr       = fill_counter_ff[IDX_W-1:0];
      mem_wdata       = fill_sat[SAMPLE_BITS-1:0];
      mem_re          = 1'b0;
      mem_raddr       = req_addr;
      div_start       = 1'b0;
      div_numer       = '0;
      div_denom       = eff_len;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in = '0;
               unique case (req_mode)
                  MODE_READ: begin
                     mem_re   = 1'b1;
                     state_in = S_READ;
                  end
                  MODE_WRITE: begin
                     mem_we    = 1'b1;
                     mem_waddr = req_addr;
                     mem_wdata = samp_w;
                     state_in  = S_FINISH;
                  end
                  MODE_CLEAR: begin
                     fill_counter_in = '0;
                     state_in        = S_CLEAR;
                  end
                  MODE_FILL: begin
                     wave_in         = req_waveform;
                     fill_counter_in = '0;
                     state_in        = S_FILL;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_READ: begin
            res_in   = rd_x[15:0];
            state_in = S_FINISH;
         end
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            if (fill_counter_ff == LEN_W'(MAX_ENTRIES - 1)) begin
               fill_counter_in = '0;
               state_in        = S_FINISH;
            end else begin
               fill_counter_in = fill_counter_ff + LEN_W'(1);
            end
         end
         S_FILL: begin
            priority if (!(is_trig || is_square || is_tri || is_ramp)) begin
               // Unknown selector: the table is left as it is.
               state_in = S_FINISH;
            end else if (fill_counter_ff == eff_len) begin
               fill_counter_in = '0;
               state_in        = S_FINISH;
            end else if (is_trig && eff_len < LEN_W'(2)) begin
               mem_we          = 1'b1;
               fill_counter_in = fill_counter_ff + LEN_W'(1);
            end else if (is_trig) begin
               div_start = 1'b1;
               div_numer = NUM_W'(fill_counter_ff) << 10;
               div_denom = eff_len - LEN_W'(1);
               state_in  = S_DIV;
            end else if (is_square || (is_tri && eff_len < LEN_W'(4))) begin
               // Short triangles write zeros.
               mem_we          = 1'b1;
               fill_counter_in = fill_counter_ff + LEN_W'(1);
            end else if (is_tri && below_quarter) begin
               div_start = 1'b1;
               div_numer = NUM_W'(fill_counter_ff) << FB;
               div_denom = is_mod ? half_len : quarter_len;
               state_in  = S_DIV;
            end else if (is_tri) begin
               mem_re    = 1'b1;
               mem_raddr = below_half ? mirror_addr[IDX_W-1:0]
                                      : IDX_W'(fill_counter_ff - half_len);
               state_in  = S_MEMRD;
            end else begin
               div_start = 1'b1;
               div_numer = NUM_W'(ramp_src) << (is_mod ? FB : SAMPLE_BITS);
               div_denom = eff_len;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               mem_we          = 1'b1;
               fill_counter_in = fill_counter_ff + LEN_W'(1);
               state_in        = S_FILL;
            end
         end
         S_MEMRD: begin
            mem_we          = 1'b1;
            fill_counter_in = fill_counter_ff + LEN_W'(1);
            state_in        = S_FILL;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         fill_counter_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         fill_counter_ff <= fill_counter_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      wave_ff      <= wave_in;
      res_ff       <= res_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign req_stall      = state_ff != S_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_done_res   = 1'b1;

   a_idle_counter_zero: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> fill_counter_ff == '0) else $error("walk counter not zero when idle");

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      (mem_we && (state_ff == S_FILL || state_ff == S_DIV || state_ff == S_MEMRD))
      |-> LEN_W'(mem_waddr) < eff_len) else $error("fill write beyond table length");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && (!rsp_valid_ff || !rsp_stall)) |=> rsp_valid_ff)
      else $error("finished command not presented");

endmodule

`default_nettype wire
